// ===== rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO
// Ring geometry, command and status codes, transaction payload structs and
// the helper that builds one result transaction from the pointer state.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  // Ring geometry. DEPTH must be a power of two; one slot always stays free.
  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // Largest number of bytes that one read, peek or skip may move.
  localparam logic [6:0] MAX_BURST = 7'd64;

  typedef logic [PTR_W-1:0] ptr_t;

  // Command codes; codes six and seven are unused and answered as no-ops.
  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_READ  = 3'd2,
    CMD_PEEK  = 3'd3,
    CMD_SKIP  = 3'd4,
    CMD_FLUSH = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_DATA  = 2'd2
  } state_t;

  // Input transaction payload.
  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_in;
    logic [6:0] burst_len;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] data_out;
    status_t    status;
    logic [6:0] moved;
    logic [7:0] fill_level;
    logic       is_full;
    logic       is_empty;
    logic       last;
  } out_item_t;

  // Build one result from the pointers as they stand after that result.
  function automatic out_item_t make_result(input logic [7:0] data,
                                            input status_t    status,
                                            input logic [6:0] moved,
                                            input ptr_t       wp,
                                            input ptr_t       rp,
                                            input logic       last);
    out_item_t   res;
    ptr_t        fill;
    logic [31:0] fill_ext;
    fill           = wp - rp;
    fill_ext       = 32'(fill);
    res.data_out   = data;
    res.status     = status;
    res.moved      = moved;
    res.fill_level = fill_ext[7:0];
    res.is_full    = ((wp + ptr_t'(1)) == rp);
    res.is_empty   = (wp == rp);
    res.last       = last;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/byte_ring_fifo_top.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_top: command-driven byte FIFO on a power-of-two ring
// Usage: each input transaction on in_* carries one command (put, get, read
// burst, peek burst, skip, flush). Results leave on out_* as transactions;
// read and peek give one result per byte, every other command gives one,
// and the final result of a command has last set. Every result carries the
// fill level and the full and empty flags after it.
// Latency: a command is accepted in IDLE and its first result is valid on
// the next cycle for put, skip, flush, and empty or zero-length requests.
// Get, read and peek fetch each byte through the registered RAM read port:
// FETCH presents the address, then DATA moves the captured data into the
// output register once it is free.
// Throughput: one command at a time; in_ready is high only in IDLE while the
// output register is free or being drained in the same cycle.
// Reset: synchronous rst_n clears both pointers, so the FIFO comes up empty.
// The byte store is not cleared; only occupied slots are ever read.
// Stall: when out_ready is low the output register holds its result, and the
// sequencer waits before loading the next byte or taking a new command.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_top
  import brf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  state_t     state_r, state_nxt;
  ptr_t       wp_r, wp_nxt;
  ptr_t       rp_r, rp_nxt;
  ptr_t       addr_r, addr_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] n_r, n_nxt;
  logic       pop_r, pop_nxt;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       wr_en;
  logic       rd_en;
  logic [7:0] rd_data;

  // Byte store.
  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_data.data_in),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // Control and pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Burst bookkeeping and result payload.
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    pop_r  <= pop_nxt;
    out_r  <= out_nxt;
  end

  // Sequencer: command decode, per-byte fetch and result loading.
  always_comb begin
    logic        out_free;
    logic        last_byte;
    logic [6:0]  req;
    logic [6:0]  n_sel;
    logic [31:0] fill_ext;
    ptr_t        fill;
    ptr_t        rp_upd;

    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    pop_nxt       = pop_r;
    out_nxt       = out_r;
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    // Requested length saturated to the burst limit, then clamped to fill.
    fill     = wp_r - rp_r;
    fill_ext = 32'(fill);
    req      = (in_data.burst_len > MAX_BURST) ? MAX_BURST : in_data.burst_len;
    n_sel    = (fill_ext < 32'(req)) ? fill_ext[6:0] : req;
    last_byte = ((cnt_r + 7'd1) == n_r);
    rp_upd    = pop_r ? (rp_r + ptr_t'(1)) : rp_r;

    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          out_valid_nxt = 1'b1;
          case (in_data.command)
            CMD_PUT: begin
              if ((wp_r + ptr_t'(1)) == rp_r) begin
                out_nxt = make_result(8'd0, ST_FULL, 7'd0, wp_r, rp_r, 1'b1);
              end else begin
                wr_en   = 1'b1;
                wp_nxt  = wp_r + ptr_t'(1);
                out_nxt = make_result(8'd0, ST_OK, 7'd1, wp_nxt, rp_r, 1'b1);
              end
            end
            CMD_GET, CMD_READ, CMD_PEEK: begin
              if (fill == '0) begin
                out_nxt = make_result(8'd0, ST_EMPTY, 7'd0, wp_r, rp_r, 1'b1);
              end else if (in_data.command != CMD_GET && n_sel == 7'd0) begin
                out_nxt = make_result(8'd0, ST_OK, 7'd0, wp_r, rp_r, 1'b1);
              end else begin
                // Start a byte-by-byte transfer; the result comes later.
                out_valid_nxt = out_valid_r && !out_ready;
                n_nxt     = (in_data.command == CMD_GET) ? 7'd1 : n_sel;
                cnt_nxt   = 7'd0;
                pop_nxt   = (in_data.command != CMD_PEEK);
                addr_nxt  = rp_r;
                state_nxt = S_FETCH;
              end
            end
            CMD_SKIP: begin
              rp_nxt  = rp_r + ptr_t'(n_sel);
              out_nxt = make_result(8'd0, ST_OK, n_sel, wp_r, rp_nxt, 1'b1);
            end
            CMD_FLUSH: begin
              rp_nxt  = wp_r;
              out_nxt = make_result(8'd0, ST_OK, 7'd0, wp_r, wp_r, 1'b1);
            end
            default: begin
              out_nxt = make_result(8'd0, ST_OK, 7'd0, wp_r, rp_r, 1'b1);
            end
          endcase
        end
      end
      S_FETCH: begin
        // Present the slot address to the RAM read port.
        rd_en     = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        // Move the fetched byte into the output register once it is free.
        if (out_free) begin
          rp_nxt        = rp_upd;
          out_nxt       = make_result(rd_data, ST_OK, n_r, wp_r, rp_upd, last_byte);
          out_valid_nxt = 1'b1;
          if (last_byte) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + ptr_t'(1);
            cnt_nxt   = cnt_r + 7'd1;
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/byte_ring_fifo_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_top_tb: self-checking testbench for the byte ring FIFO
// Drives command transactions into the FIFO and predicts every result from a
// private copy of the ring and its pointers. Each result transaction is
// compared field by field with the oldest prediction. Directed tests cover
// the empty and full corners, zero and oversized burst lengths, skip, flush
// and the unused command codes. A random mix with varying back pressure on
// both channels follows.
// ----------------------------------------------------------------------------

module byte_ring_fifo_top_tb;
  import brf_pkg::*;

  // The two command codes that the block answers as no-ops.
  localparam logic [2:0] CMD_NOP_6 = 3'd6;
  localparam logic [2:0] CMD_NOP_7 = 3'd7;

  localparam int unsigned MAX_SHOWN = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // Idle rates in percent for the sending and receiving sides.
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 54;

  // Private copy of the FIFO contents and pointers.
  logic [7:0] ring_mem [DEPTH];
  ptr_t       wr_ptr = '0;
  ptr_t       rd_ptr = '0;

  // Results predicted but not yet seen on the output channel.
  out_item_t  pending_results [$];
  int unsigned mismatch_count = 0;

  byte_ring_fifo_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned held_bytes();
    return int'(ptr_t'(wr_ptr - rd_ptr));
  endfunction

  function automatic logic ring_is_full();
    return ptr_t'(wr_ptr + ptr_t'(1)) == rd_ptr;
  endfunction

  // Queue one expected result, with flags taken from the pointers as they are now.
  task automatic queue_result(input logic [7:0] data, input status_t st,
                              input int unsigned moved, input logic last);
    out_item_t res;
    res.data_out   = data;
    res.status     = st;
    res.moved      = 7'(moved);
    res.fill_level = 8'(held_bytes());
    res.is_full    = ring_is_full();
    res.is_empty   = (wr_ptr == rd_ptr);
    res.last       = last;
    pending_results.push_back(res);
  endtask

  // Apply one accepted command to the private ring and queue what it yields.
  task automatic predict_results(input in_item_t item);
    int unsigned req;
    int unsigned n;
    logic [7:0]  d;
    req = (item.burst_len > MAX_BURST) ? int'(MAX_BURST) : int'(item.burst_len);
    case (item.command)
      CMD_PUT: begin
        if (ring_is_full()) begin
          queue_result(8'h00, ST_FULL, 0, 1'b1);
        end else begin
          ring_mem[wr_ptr] = item.data_in;
          wr_ptr = wr_ptr + ptr_t'(1);
          queue_result(8'h00, ST_OK, 1, 1'b1);
        end
      end
      CMD_GET: begin
        if (held_bytes() == 0) begin
          queue_result(8'h00, ST_EMPTY, 0, 1'b1);
        end else begin
          d = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + ptr_t'(1);
          queue_result(d, ST_OK, 1, 1'b1);
        end
      end
      CMD_READ, CMD_PEEK: begin
        n = held_bytes();
        if (n == 0) begin
          queue_result(8'h00, ST_EMPTY, 0, 1'b1);
        end else if (req == 0) begin
          queue_result(8'h00, ST_OK, 0, 1'b1);
        end else begin
          if (n > req) n = req;
          for (int i = 0; i < n; i++) begin
            if (item.command == CMD_READ) begin
              d = ring_mem[rd_ptr];
              rd_ptr = rd_ptr + ptr_t'(1);
            end else begin
              d = ring_mem[ptr_t'(rd_ptr + i)];
            end
            queue_result(d, ST_OK, n, i == n - 1);
          end
        end
      end
      CMD_SKIP: begin
        n = held_bytes();
        if (n > req) n = req;
        rd_ptr = rd_ptr + ptr_t'(n);
        queue_result(8'h00, ST_OK, n, 1'b1);
      end
      CMD_FLUSH: begin
        rd_ptr = wr_ptr;
        queue_result(8'h00, ST_OK, 0, 1'b1);
      end
      default: begin
        queue_result(8'h00, ST_OK, 0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("data=%02h status=%0d moved=%0d fill=%0d full=%b empty=%b last=%b",
                     r.data_out, r.status, r.moved, r.fill_level, r.is_full,
                     r.is_empty, r.last);
  endfunction

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      note_error({"unexpected result ", fmt_result(got)});
    end else begin
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out || got.status !== want.status ||
          got.moved !== want.moved || got.fill_level !== want.fill_level ||
          got.is_full !== want.is_full || got.is_empty !== want.is_empty ||
          got.last !== want.last) begin
        note_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
      end
    end
  endtask

  // Check each result transaction and randomize back pressure on the output.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one command transaction, with random idle cycles ahead of it.
  task automatic send_cmd(input cmd_t cmd, input logic [7:0] data,
                          input logic [6:0] len);
    in_item_t item;
    item.command   = cmd;
    item.data_in   = data;
    item.burst_len = len;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(item);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_all_delivered();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command but put on an empty FIFO, plus the unused codes.
  task automatic test_empty_fifo();
    send_cmd(CMD_GET, 8'h00, 7'd0);
    send_cmd(CMD_READ, 8'h00, 7'd4);
    send_cmd(CMD_PEEK, 8'h00, 7'd64);
    send_cmd(CMD_SKIP, 8'h00, 7'd5);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0);
    send_cmd(cmd_t'(CMD_NOP_6), 8'hFF, 7'd127);
    send_cmd(cmd_t'(CMD_NOP_7), 8'h00, 7'd0);
  endtask

  // Single operations, zero and oversized bursts, skip and flush with data.
  task automatic test_basic_ops();
    send_cmd(CMD_PUT, 8'h00, 7'd0);
    send_cmd(CMD_PUT, 8'hFF, 7'd127);
    send_cmd(CMD_PUT, 8'hA5, 7'd0);
    send_cmd(CMD_PUT, 8'h5A, 7'd0);
    send_cmd(CMD_PEEK, 8'h00, 7'd0);
    send_cmd(CMD_READ, 8'h00, 7'd0);
    send_cmd(CMD_PEEK, 8'h00, 7'd127);
    send_cmd(CMD_READ, 8'h00, 7'd2);
    send_cmd(CMD_GET, 8'h00, 7'd0);
    send_cmd(cmd_t'(CMD_NOP_6), 8'h00, 7'd3);
    send_cmd(CMD_SKIP, 8'h00, 7'd64);
    send_cmd(CMD_PUT, 8'h3C, 7'd0);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0);
  endtask

  // Fill the ring to capacity, overflow it, then drain with long bursts.
  task automatic test_full_fifo();
    wait_all_delivered();
    for (int i = 0; i < DEPTH - 1; i++) send_cmd(CMD_PUT, 8'($urandom), 7'd0);
    send_cmd(CMD_PUT, 8'hEE, 7'd0);
    send_cmd(CMD_GET, 8'h00, 7'd0);
    send_cmd(CMD_PUT, 8'h77, 7'd0);
    send_cmd(CMD_PUT, 8'h11, 7'd0);
    send_cmd(CMD_PEEK, 8'h00, 7'd64);
    send_cmd(CMD_READ, 8'h00, 7'd100);
    send_cmd(CMD_SKIP, 8'h00, 7'd127);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0);
  endtask

  // Random commands; bulk writes now and then push the fill level up.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    cmd_t        cmd;
    logic [6:0]  len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        run_len = $urandom_range(8, 40);
        for (int i = 0; i < run_len; i++) send_cmd(CMD_PUT, 8'($urandom), 7'($urandom));
        sent += run_len;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40)      cmd = CMD_PUT;
        else if (pick < 53) cmd = CMD_GET;
        else if (pick < 66) cmd = CMD_READ;
        else if (pick < 79) cmd = CMD_PEEK;
        else if (pick < 89) cmd = CMD_SKIP;
        else if (pick < 94) cmd = CMD_FLUSH;
        else if (pick < 97) cmd = cmd_t'(CMD_NOP_6);
        else                cmd = cmd_t'(CMD_NOP_7);
        pick = $urandom_range(99);
        if (pick < 70)      len = 7'($urandom_range(0, 8));
        else if (pick < 90) len = 7'($urandom_range(0, 64));
        else                len = 7'($urandom_range(65, 127));
        send_cmd(cmd, 8'($urandom), len);
        sent++;
      end
    end
  endtask

  // Random mix under three back-pressure settings.
  task automatic test_random_mix();
    send_idle_pct = 35;
    recv_idle_pct = 54;
    run_random(54);
    send_idle_pct = 54;
    recv_idle_pct = 35;
    run_random(53);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(53);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_fifo();
    test_basic_ops();
    test_full_fifo();
    test_random_mix();
    wait_all_delivered();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("byte_ring_fifo_top_tb: done, clean");
    end else begin
      $display("byte_ring_fifo_top_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #(5_000_000);
    $display("byte_ring_fifo_top_tb: done, errors");
    $finish;
  end

endmodule
